// ===== hdl/scdk_pkg.sv =====
// Shared types, constants and key tables for the set-1 scan code decoder.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package scdk_pkg;

    // Key queue geometry: ring of DEPTH slots, at most DEPTH-1 keys stored
    localparam int DEPTH = 64;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam int KEY_W  = 7;
    localparam int SCAN_W = 8;

    typedef logic [PTR_W-1:0]  ptr_t;
    typedef logic [KEY_W-1:0]  key_t;
    typedef logic [SCAN_W-1:0] scan_t;

    // Item commands
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Special scan bytes and key codes
    localparam scan_t SC_EXT_PREFIX   = 8'hE0;
    localparam scan_t SC_PAUSE_PREFIX = 8'hE1;
    localparam scan_t SC_INDEX_MASK   = 8'h7F;
    localparam key_t  NO_KEY          = 7'd0;
    localparam key_t  PAUSE_KEY       = 7'd101;

    // Queue control from the decoder and status back from the queue
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctrl_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_stat_t;

    // Ring pointer advance, wraps at DEPTH-1
    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == ptr_t'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + ptr_t'(1);
        end
        return r;
    endfunction

    // Normal table: codes 0x01..0x53 map to themselves, plus F11/F12
    function automatic key_t normal_key(input logic [6:0] idx);
        key_t k;
        if (idx >= 7'h01 && idx <= 7'h53)
        begin
            k = idx;
        end
        else
        begin
            case (idx)
                7'h57:   k = 7'd84;   // F11
                7'h58:   k = 7'd85;   // F12
                default: k = NO_KEY;
            endcase
        end
        return k;
    endfunction

    // Extended table, used after an E0 prefix
    function automatic key_t ext_key(input logic [6:0] idx);
        key_t k;
        case (idx)
            7'h1D:   k = 7'd86;   // right ctrl
            7'h38:   k = 7'd87;   // right alt
            7'h47:   k = 7'd88;   // home
            7'h48:   k = 7'd89;   // up
            7'h49:   k = 7'd90;   // page up
            7'h4B:   k = 7'd91;   // left
            7'h4D:   k = 7'd92;   // right
            7'h4F:   k = 7'd93;   // end
            7'h50:   k = 7'd94;   // down
            7'h51:   k = 7'd95;   // page down
            7'h52:   k = 7'd96;   // insert
            7'h53:   k = 7'd97;   // delete
            7'h5B:   k = 7'd98;   // left gui
            7'h5C:   k = 7'd99;   // right gui
            7'h5D:   k = 7'd100;  // apps
            7'h37:   k = 7'd102;  // print screen
            default: k = NO_KEY;
        endcase
        return k;
    endfunction

endpackage

// ===== hdl/scdk_in_if.sv =====
// Valid/ready channel carrying scan code and read-request items.
// Depends on scdk_pkg for the payload types.
`timescale 1ns / 1ps

interface scdk_in_if import scdk_pkg::*;;
    logic  valid;
    logic  ready;
    logic  cmd;
    scan_t scan_code;

    modport source (output valid, output cmd, output scan_code, input ready);
    modport sink   (input valid, input cmd, input scan_code, output ready);
endinterface

// ===== hdl/scdk_out_if.sv =====
// Valid/ready channel carrying decoder result items.
// Depends on scdk_pkg for the payload types.
`timescale 1ns / 1ps

interface scdk_out_if import scdk_pkg::*;;
    logic valid;
    logic ready;
    key_t key_code;
    logic key_pushed;
    logic key_dropped;

    modport source (output valid, output key_code, output key_pushed, output key_dropped,
                    input ready);
    modport sink   (input valid, input key_code, input key_pushed, input key_dropped,
                    output ready);
endinterface

// ===== hdl/scdk_key_fifo.sv =====
// Ring queue of key codes with a prefetched head register.
// Depends on scdk_pkg for geometry, pointer helper and control structs.
`timescale 1ns / 1ps

module scdk_key_fifo import scdk_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  fifo_ctrl_t ctrl,
    input  key_t       wr_key,
    output fifo_stat_t stat,
    output key_t       head_key
);

    key_t mem [DEPTH];
    ptr_t wr_ptr_reg;
    ptr_t wr_ptr_next;
    ptr_t rd_ptr_reg;
    ptr_t rd_ptr_next;
    key_t head_reg;

    // Status from current pointers
    assign stat.empty = (wr_ptr_reg == rd_ptr_reg);
    assign stat.full  = (ptr_inc(wr_ptr_reg) == rd_ptr_reg);
    assign head_key   = head_reg;

    // Pointer updates; caller only pushes when not full, pops when not empty
    always_comb
    begin
        wr_ptr_next = ctrl.push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = ctrl.pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    // Storage write and registered head read, with bypass when the slot
    // being written is the one the head will point at
    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            mem[wr_ptr_reg] <= wr_key;
        end
        if (ctrl.push && (wr_ptr_reg == rd_ptr_next))
        begin
            head_reg <= wr_key;
        end
        else
        begin
            head_reg <= mem[rd_ptr_next];
        end
    end

endmodule

// ===== hdl/scan_code_decoder_with_key_fifo.sv =====
// Set-1 scan code decoder with key queue: top level.
// Depends on scdk_pkg, scdk_in_if, scdk_out_if and scdk_key_fifo.
//
//  channel   dir  payload                           item
//  scan_in   in   cmd, scan_code                    one scan byte or one read request
//  key_out   out  key_code, key_pushed, key_dropped one result per input item
//
// One item per cycle sustained while key_out accepts; each item passes through the input register,
// then decode and queue update into the result register.
// The queue head is prefetched into a register so a read takes its key straight from it.
// rst_n clears the flags, queue pointers and both valid registers; no clearing pass.
// A stalled result holds the input register, which holds scan_in.ready low once full.
`timescale 1ns / 1ps

module scan_code_decoder_with_key_fifo import scdk_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    scdk_in_if.sink           scan_in,
    scdk_out_if.source        key_out
);

    // Input register
    logic  inp_valid_reg;
    logic  inp_cmd_reg;
    scan_t inp_scan_reg;

    // Decoder flags
    logic ext_reg;
    logic ext_next;
    logic pause_reg;
    logic pause_next;

    // Result register
    logic out_valid_reg;
    key_t out_code_reg;
    logic out_pushed_reg;
    logic out_dropped_reg;

    logic       advance;
    fifo_ctrl_t q_ctrl;
    fifo_stat_t q_stat;
    key_t       q_head;
    key_t       dec_key;
    key_t       res_code;
    logic       res_pushed;
    logic       res_dropped;

    assign advance       = inp_valid_reg && (!out_valid_reg || key_out.ready);
    assign scan_in.ready = !inp_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inp_valid_reg <= 1'b0;
        end
        else if (scan_in.ready)
        begin
            inp_valid_reg <= scan_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_in.ready && scan_in.valid)
        begin
            inp_cmd_reg  <= scan_in.cmd;
            inp_scan_reg <= scan_in.scan_code;
        end
    end

    // Decode and queue control for the item in the input register
    always_comb
    begin
        ext_next    = ext_reg;
        pause_next  = pause_reg;
        dec_key     = NO_KEY;
        q_ctrl      = '0;
        res_code    = NO_KEY;
        res_pushed  = 1'b0;
        res_dropped = 1'b0;
        if (inp_cmd_reg == CMD_READ)
        begin
            if (!q_stat.empty)
            begin
                q_ctrl.pop = 1'b1;
                res_code   = q_head;
            end
        end
        else if (pause_reg)
        begin
            // byte after the pause prefix is swallowed
            pause_next = 1'b0;
        end
        else if (inp_scan_reg == SC_EXT_PREFIX)
        begin
            ext_next = 1'b1;
        end
        else
        begin
            if (inp_scan_reg == SC_PAUSE_PREFIX)
            begin
                pause_next = 1'b1;
                dec_key    = PAUSE_KEY;
            end
            else if (ext_reg)
            begin
                dec_key  = ext_key(inp_scan_reg[6:0]);
                ext_next = 1'b0;
            end
            else
            begin
                dec_key = normal_key(inp_scan_reg[6:0]);
            end
            if (dec_key != NO_KEY)
            begin
                if (q_stat.full)
                begin
                    res_dropped = 1'b1;
                end
                else
                begin
                    q_ctrl.push = 1'b1;
                    res_pushed  = 1'b1;
                end
            end
        end
        // state changes only when the item actually moves on
        if (!advance)
        begin
            ext_next   = ext_reg;
            pause_next = pause_reg;
            q_ctrl     = '0;
        end
    end

    // Decoder flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ext_reg   <= 1'b0;
            pause_reg <= 1'b0;
        end
        else
        begin
            ext_reg   <= ext_next;
            pause_reg <= pause_next;
        end
    end

    // Key queue
    scdk_key_fifo u_fifo
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (q_ctrl),
        .wr_key   (dec_key),
        .stat     (q_stat),
        .head_key (q_head)
    );

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (key_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg    <= res_code;
            out_pushed_reg  <= res_pushed;
            out_dropped_reg <= res_dropped;
        end
    end

    assign key_out.valid       = out_valid_reg;
    assign key_out.key_code    = out_code_reg;
    assign key_out.key_pushed  = out_pushed_reg;
    assign key_out.key_dropped = out_dropped_reg;

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the set-1 scan code decoder with key queue.
// Depends on scdk_pkg, scdk_in_if, scdk_out_if and the top level of the block.
`timescale 1ns / 1ps

module testbench import scdk_pkg::*;;

    typedef struct packed {
        key_t key_code;
        logic pushed;
        logic dropped;
    } decode_result_t;

    typedef struct packed {
        logic           cmd;
        scan_t          scan_code;
        logic           fixed;      // want holds a typed-in result
        decode_result_t want;
    } scan_item_t;

    localparam decode_result_t NO_EFFECT = '{NO_KEY, 1'b0, 1'b0};
    localparam decode_result_t QUEUED    = '{NO_KEY, 1'b1, 1'b0};

    // Extended keys: scan index and the key code it decodes to
    localparam scan_t EXT_SCANS [16] = '{8'h1D, 8'h38, 8'h47, 8'h48, 8'h49, 8'h4B,
                                        8'h4D, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53,
                                        8'h5B, 8'h5C, 8'h5D, 8'h37};
    localparam key_t  EXT_KEYS  [16] = '{7'd86, 7'd87, 7'd88, 7'd89, 7'd90, 7'd91,
                                        7'd92, 7'd93, 7'd94, 7'd95, 7'd96, 7'd97,
                                        7'd98, 7'd99, 7'd100, 7'd102};

    logic clk = 1'b0;
    logic rst_n;

    scdk_in_if  scan_ch ();
    scdk_out_if key_ch ();

    scan_code_decoder_with_key_fifo uut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .scan_in (scan_ch),
        .key_out (key_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Decoder state as predicted from the accepted items
    logic ext_pending;
    logic swallow_next;
    key_t key_model_q [$];
    key_t plain_tbl [128];
    key_t prefixed_tbl [128];

    decode_result_t decode_due_q [$];
    scan_item_t     stim_q [$];

    int   fail_cnt = 0;
    logic idle_on = 1'b1;
    logic hold_off = 1'b0;
    logic pressure_go = 1'b0;

    // Directed items: empty read, table extremes, prefix and pause cases, then drain
    scan_item_t directed_tbl [24] = '{
        '{CMD_READ, 8'h00, 1'b1, NO_EFFECT},               // read on empty queue
        '{CMD_SCAN, 8'h00, 1'b1, NO_EFFECT},               // unmapped byte
        '{CMD_SCAN, 8'h01, 1'b1, QUEUED},                  // lowest mapped code
        '{CMD_SCAN, 8'h81, 1'b1, QUEUED},                  // its release queues it again
        '{CMD_SCAN, 8'h58, 1'b0, NO_EFFECT},               // F12, top of normal table
        '{CMD_SCAN, 8'hFF, 1'b1, NO_EFFECT},               // all ones, unmapped
        '{CMD_SCAN, SC_EXT_PREFIX, 1'b1, NO_EFFECT},
        '{CMD_SCAN, SC_EXT_PREFIX, 1'b1, NO_EFFECT},       // prefix twice stays set
        '{CMD_SCAN, 8'h48, 1'b0, NO_EFFECT},               // extended up arrow
        '{CMD_SCAN, SC_EXT_PREFIX, 1'b1, NO_EFFECT},
        '{CMD_SCAN, 8'h54, 1'b1, NO_EFFECT},               // extended unmapped, clears prefix
        '{CMD_SCAN, 8'h1D, 1'b0, NO_EFFECT},               // now decoded from normal table
        '{CMD_SCAN, SC_EXT_PREFIX, 1'b1, NO_EFFECT},
        '{CMD_SCAN, SC_PAUSE_PREFIX, 1'b1, QUEUED},        // pause keeps the prefix
        '{CMD_SCAN, SC_PAUSE_PREFIX, 1'b1, NO_EFFECT},     // swallowed, whatever its value
        '{CMD_SCAN, 8'hB7, 1'b0, NO_EFFECT},               // extended print screen release
        '{CMD_READ, 8'h5A, 1'b1, '{7'd1, 1'b0, 1'b0}},
        '{CMD_READ, 8'hA5, 1'b1, '{7'd1, 1'b0, 1'b0}},
        '{CMD_READ, 8'hFF, 1'b0, NO_EFFECT},
        '{CMD_READ, 8'h00, 1'b0, NO_EFFECT},
        '{CMD_READ, 8'h00, 1'b0, NO_EFFECT},
        '{CMD_READ, 8'h00, 1'b1, '{PAUSE_KEY, 1'b0, 1'b0}},
        '{CMD_READ, 8'h00, 1'b0, NO_EFFECT},
        '{CMD_READ, 8'h00, 1'b1, NO_EFFECT}                // queue drained again
    };

    // Predicted result of one item; updates the predicted state
    function automatic decode_result_t decode_scan_item(input logic cmd, input scan_t sc);
        decode_result_t r;
        key_t           k;
        r = NO_EFFECT;
        k = NO_KEY;
        if (cmd == CMD_READ)
        begin
            if (key_model_q.size() != 0)
            begin
                r.key_code = key_model_q.pop_front();
            end
        end
        else if (swallow_next)
        begin
            swallow_next = 1'b0;
        end
        else if (sc == SC_EXT_PREFIX)
        begin
            ext_pending = 1'b1;
        end
        else
        begin
            if (sc == SC_PAUSE_PREFIX)
            begin
                swallow_next = 1'b1;
                k = PAUSE_KEY;
            end
            else if (ext_pending)
            begin
                k = prefixed_tbl[sc[6:0]];
                ext_pending = 1'b0;
            end
            else
            begin
                k = plain_tbl[sc[6:0]];
            end
            if (k != NO_KEY)
            begin
                if (key_model_q.size() < DEPTH - 1)
                begin
                    key_model_q.push_back(k);
                    r.pushed = 1'b1;
                end
                else
                begin
                    r.dropped = 1'b1;
                end
            end
        end
        return r;
    endfunction

    task automatic queue_scan(input scan_t b);
        stim_q.push_back('{CMD_SCAN, b, 1'b0, NO_EFFECT});
    endtask

    task automatic queue_read();
        stim_q.push_back('{CMD_READ, scan_t'($urandom_range(0, 255)), 1'b0, NO_EFFECT});
    endtask

    // One keyboard event: mostly well-formed sequences, some noise and broken ones
    task automatic queue_key_event();
        int    pick;
        scan_t b;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            b = scan_t'($urandom_range(1, 8'h55));
            if (b > 8'h53)
            begin
                b = b + 8'd3;   // F11 / F12
            end
            b[7] = 1'($urandom_range(0, 1));
            queue_scan(b);
        end
        else if (pick < 65)
        begin
            queue_scan(SC_EXT_PREFIX);
            if ($urandom_range(0, 3) == 0)
            begin
                b = scan_t'($urandom_range(0, 127));
            end
            else
            begin
                b = EXT_SCANS[$urandom_range(0, 15)];
            end
            b[7] = 1'($urandom_range(0, 1));
            queue_scan(b);
        end
        else if (pick < 70)
        begin
            // full pause key sequence
            queue_scan(SC_PAUSE_PREFIX);
            queue_scan(8'h1D);
            queue_scan(8'h45);
            queue_scan(SC_PAUSE_PREFIX);
            queue_scan(8'h9D);
            queue_scan(8'hC5);
        end
        else if (pick < 88)
        begin
            queue_scan(scan_t'($urandom_range(0, 255)));
        end
        else if (pick < 94)
        begin
            queue_scan(SC_EXT_PREFIX);
            queue_scan(SC_EXT_PREFIX);
        end
        else
        begin
            queue_scan(SC_PAUSE_PREFIX);
        end
    endtask

    task automatic queue_segment(input int len, input int read_pct);
        int j;
        for (j = 0; j < len; j++)
        begin
            if ($urandom_range(0, 99) < read_pct)
            begin
                queue_read();
            end
            else
            begin
                queue_key_event();
            end
        end
    endtask

    // Offer queued items one by one; predict each at acceptance
    task automatic run_stim();
        scan_item_t     it;
        decode_result_t pred;
        while (stim_q.size() != 0)
        begin
            it = stim_q.pop_front();
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                scan_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            scan_ch.valid     <= 1'b1;
            scan_ch.cmd       <= it.cmd;
            scan_ch.scan_code <= it.scan_code;
            @(posedge clk);
            while (scan_ch.ready !== 1'b1)
            begin
                @(posedge clk);
            end
            pred = decode_scan_item(it.cmd, it.scan_code);
            decode_due_q.push_back(it.fixed ? it.want : pred);
        end
    endtask

    // Main sequence
    initial
    begin
        int i;
        int n_rand;
        rst_n             <= 1'b0;
        scan_ch.valid     <= 1'b0;
        scan_ch.cmd       <= CMD_SCAN;
        scan_ch.scan_code <= '0;
        ext_pending  = 1'b0;
        swallow_next = 1'b0;
        for (i = 0; i < 128; i++)
        begin
            plain_tbl[i]    = (i >= 1 && i <= 8'h53) ? key_t'(i) : NO_KEY;
            prefixed_tbl[i] = NO_KEY;
        end
        plain_tbl[8'h57] = 7'd84;
        plain_tbl[8'h58] = 7'd85;
        for (i = 0; i < 16; i++)
        begin
            prefixed_tbl[EXT_SCANS[i][6:0]] = EXT_KEYS[i];
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_tbl[i])
        begin
            stim_q.push_back(directed_tbl[i]);
        end
        run_stim();

        // Hold the output off, then fill past capacity and drain
        pressure_go <= 1'b1;
        for (i = 0; i < 70; i++)
        begin
            queue_scan({1'($urandom_range(0, 1)), 7'($urandom_range(1, 8'h53))});
        end
        for (i = 0; i < 70; i++)
        begin
            queue_read();
        end
        run_stim();

        // Random segments, each with its own read mix and idling choice
        n_rand = 0;
        while (n_rand < 400)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            queue_segment($urandom_range(20, 80), $urandom_range(10, 60));
            n_rand += stim_q.size();
            run_stim();
        end

        // Closing stretch with no idling on either side
        idle_on = 1'b0;
        queue_segment(100, 40);
        run_stim();
        scan_ch.valid <= 1'b0;

        while (decode_due_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (10) @(posedge clk);
        if (fail_cnt == 0)
        begin
            $display("== PASS ==");
        end
        else
        begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // Long output hold-off so the block fills and stalls its input
    initial
    begin
        wait (pressure_go === 1'b1);
        hold_off <= 1'b1;
        repeat (300) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Result side: compare each item, then pick ready for the next cycle
    initial
    begin
        int             stall_left;
        decode_result_t got;
        decode_result_t due;
        stall_left = 0;
        key_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (key_ch.valid === 1'b1 && key_ch.ready === 1'b1)
            begin
                got.key_code = key_ch.key_code;
                got.pushed   = key_ch.key_pushed;
                got.dropped  = key_ch.key_dropped;
                if (decode_due_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                    begin
                        $display("%0t: result with nothing pending: %0d/%0b/%0b",
                                 $realtime, got.key_code, got.pushed, got.dropped);
                    end
                end
                else
                begin
                    due = decode_due_q.pop_front();
                    if (got !== due)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                        begin
                            $display("%0t: code/pushed/dropped exp %0d/%0b/%0b got %0d/%0b/%0b",
                                     $realtime, due.key_code, due.pushed, due.dropped,
                                     got.key_code, got.pushed, got.dropped);
                        end
                    end
                end
            end
            if (hold_off)
            begin
                key_ch.ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                key_ch.ready <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 11) - 1;
                key_ch.ready <= 1'b0;
            end
            else
            begin
                key_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule
